// ===== sv/ranked_tier_prefix_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// ranked tier prefix encoder assertion macros
// concurrent assertion helpers clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RANKED_TIER_PREFIX_ENCODER_DEFINES_SVH
`define RANKED_TIER_PREFIX_ENCODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RTPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RTPE_ASSERT(label, prop, msg)
`define RTPE_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== sv/rtpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpe_pkg
// constants, codes and sequencer states of the ranked tier prefix encoder
// ----------------------------------------------------------------------------
`default_nettype none
package rtpe_pkg;
  localparam int SMALL_TIER   = 4;
  localparam int MEDIUM_TIER  = 16;
  localparam int BOOK_ENTRIES = 84;
  localparam int COUNT_BITS   = 24;
  localparam int BOOK_AW      = $clog2(BOOK_ENTRIES);
  localparam int ACC_BITS     = 42;
  localparam logic [10:0] WORDS_MAX = 11'd2047;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_SYMBOL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_B_RDV, ST_B_LDV, ST_B_RDU, ST_B_CMP,
    ST_B_WR, ST_ENC_RD, ST_ENC_ADD, ST_ENC_W1, ST_ENC_W2, ST_RD_RD, ST_RD_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== sv/ranked_tier_prefix_encoder.sv =====
// ----------------------------------------------------------------------------
// ranked_tier_prefix_encoder
// two-pass byte coder: histogram, rank-built codebook, tiered prefix packing
// ----------------------------------------------------------------------------
// One item at a time; in_tready is high only while the sequencer is idle. A
// count byte does a read-modify-write of the count memory, a read does a
// codebook memory read plus output load, and an encode byte does a rank read,
// a code add and two word-emit states, plus any wait for the output register
// to drain. The count byte that ends a pass then runs the ranking: one shared
// comparator walks the count memory through its single read port, after
// which the histogram valid bits are cleared at once. The result register
// lets the next item in while a result waits.
`default_nettype none
`include "ranked_tier_prefix_encoder_defines.svh"
module ranked_tier_prefix_encoder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // data_byte[7:0], rank_index[14:8], zero
  input  wire  [1:0]  in_tuser,   // mode[1:0]
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,  // packed_word[31:0], codebook_symbol[39:32],
                                  // segment_length_bytes[52:40], zero
  output logic        out_tuser,  // result_kind
  output logic        out_tlast   // segment_end
);
  localparam int CB = rtpe_pkg::COUNT_BITS;
  localparam int AB = rtpe_pkg::ACC_BITS;

  rtpe_pkg::state_t state_r, state_nxt;

  logic [7:0]  byte_r;
  logic [6:0]  idx_r;
  logic        last_r;
  logic [7:0]  v_r, u_r, rank_r;
  logic [CB-1:0] cv_r;
  logic [AB-1:0] acc_r;
  logic [5:0]  pend_r;
  logic [10:0] words_r;
  logic        rank_ok_r, book_ok_r;
  logic [255:0] vld_r;

  logic        out_valid_r, out_kind_r, out_end_r;
  logic [31:0] out_word_r;
  logic [7:0]  out_sym_r;
  logic [12:0] out_len_r;

  logic [CB-1:0] cnt_mem [256];
  logic [7:0]    rank_mem [256];
  logic [7:0]    book_mem [rtpe_pkg::BOOK_ENTRIES];
  logic [CB-1:0] cnt_q;
  logic          cnt_vq;
  logic [7:0]    rank_q, book_q;

  logic       accept, out_free;
  logic       cnt_we, rank_we, book_we, w1_emit, w2_emit, rd_emit, out_load;
  logic [7:0] cnt_addr;
  logic [CB-1:0] cnt_eff;
  logic       beats, idx_in_book;
  logic [7:0] rank_eff;
  logic [10:0] code;
  logic [5:0] width;
  logic [10:0] words_inc;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_eff  = cnt_vq ? cnt_q : '0;
  assign beats    = (cnt_eff > cv_r) || ((cnt_eff == cv_r) && (u_r < v_r));
  assign idx_in_book = ({1'b0, idx_r} < 8'(rtpe_pkg::BOOK_ENTRIES));
  assign rank_eff  = rank_ok_r ? rank_q : byte_r;
  assign words_inc = (words_r == rtpe_pkg::WORDS_MAX) ? words_r : words_r + 11'd1;

  // tier code, sent lsb first
  always_comb begin
    if (rank_eff < 8'(rtpe_pkg::SMALL_TIER)) begin
      code  = {7'd0, rank_eff[2:0], 1'b0};
      width = 6'd3;
    end else if (rank_eff < 8'(rtpe_pkg::SMALL_TIER + rtpe_pkg::MEDIUM_TIER)) begin
      code  = {3'd0, 8'(rank_eff - 8'(rtpe_pkg::SMALL_TIER)) << 2} | 11'h1;
      width = 6'd6;
    end else if (rank_eff < 8'(rtpe_pkg::BOOK_ENTRIES)) begin
      code  = 11'({3'd0,
                   8'(rank_eff - 8'(rtpe_pkg::SMALL_TIER + rtpe_pkg::MEDIUM_TIER))}
              << 3) | 11'h3;
      width = 6'd9;
    end else begin
      code  = {byte_r, 3'h7};
      width = 6'd11;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtpe_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_tuser)
            rtpe_pkg::MODE_COUNT:  state_nxt = rtpe_pkg::ST_CNT_RD;
            rtpe_pkg::MODE_ENCODE: state_nxt = rtpe_pkg::ST_ENC_RD;
            rtpe_pkg::MODE_READ:   state_nxt = rtpe_pkg::ST_RD_RD;
            default:               state_nxt = rtpe_pkg::ST_IDLE;
          endcase
        end
      end
      rtpe_pkg::ST_CNT_RD:  state_nxt = rtpe_pkg::ST_CNT_WR;
      rtpe_pkg::ST_CNT_WR:  state_nxt = last_r ? rtpe_pkg::ST_B_RDV : rtpe_pkg::ST_IDLE;
      rtpe_pkg::ST_B_RDV:   state_nxt = rtpe_pkg::ST_B_LDV;
      rtpe_pkg::ST_B_LDV:   state_nxt = rtpe_pkg::ST_B_RDU;
      rtpe_pkg::ST_B_RDU:   state_nxt = rtpe_pkg::ST_B_CMP;
      rtpe_pkg::ST_B_CMP:   state_nxt = (u_r == 8'hFF) ? rtpe_pkg::ST_B_WR : rtpe_pkg::ST_B_RDU;
      rtpe_pkg::ST_B_WR:    state_nxt = (v_r == 8'hFF) ? rtpe_pkg::ST_IDLE : rtpe_pkg::ST_B_RDV;
      rtpe_pkg::ST_ENC_RD:  state_nxt = rtpe_pkg::ST_ENC_ADD;
      rtpe_pkg::ST_ENC_ADD: state_nxt = rtpe_pkg::ST_ENC_W1;
      rtpe_pkg::ST_ENC_W1: begin
        if (pend_r < 6'd32 || out_free) state_nxt = rtpe_pkg::ST_ENC_W2;
      end
      rtpe_pkg::ST_ENC_W2: begin
        if (!last_r || pend_r == 6'd0 || out_free) state_nxt = rtpe_pkg::ST_IDLE;
      end
      rtpe_pkg::ST_RD_RD:   state_nxt = rtpe_pkg::ST_RD_OUT;
      rtpe_pkg::ST_RD_OUT:  if (out_free) state_nxt = rtpe_pkg::ST_IDLE;
      default:              state_nxt = rtpe_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == rtpe_pkg::ST_IDLE);
    cnt_we    = (state_r == rtpe_pkg::ST_CNT_WR);
    rank_we   = (state_r == rtpe_pkg::ST_B_WR);
    book_we   = rank_we && (rank_r < 8'(rtpe_pkg::BOOK_ENTRIES));
    w1_emit   = (state_r == rtpe_pkg::ST_ENC_W1) && (pend_r >= 6'd32) && out_free;
    w2_emit   = (state_r == rtpe_pkg::ST_ENC_W2) && last_r && (pend_r != 6'd0) &&
                out_free;
    rd_emit   = (state_r == rtpe_pkg::ST_RD_OUT) && out_free;
    out_load  = w1_emit || w2_emit || rd_emit;
    case (state_r)
      rtpe_pkg::ST_B_RDV: cnt_addr = v_r;
      rtpe_pkg::ST_B_RDU: cnt_addr = u_r;
      default:            cnt_addr = byte_r;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[byte_r] <= (cnt_eff == rtpe_pkg::COUNT_MAX) ? cnt_eff : cnt_eff + CB'(1);
    end
    cnt_q  <= cnt_mem[cnt_addr];
    cnt_vq <= vld_r[cnt_addr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[v_r] <= rank_r;
    rank_q <= rank_mem[byte_r];
  end

  always_ff @(posedge clk) begin
    if (book_we) book_mem[rank_r[rtpe_pkg::BOOK_AW-1:0]] <= v_r;
    if (idx_in_book) book_q <= book_mem[idx_r[rtpe_pkg::BOOK_AW-1:0]];
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtpe_pkg::ST_IDLE;
      vld_r       <= '0;
      rank_ok_r   <= 1'b0;
      book_ok_r   <= 1'b0;
      acc_r       <= '0;
      pend_r      <= '0;
      words_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cnt_we) vld_r[byte_r] <= 1'b1;
      if (rank_we && v_r == 8'hFF) begin
        vld_r     <= '0;
        rank_ok_r <= 1'b1;
        book_ok_r <= 1'b1;
      end
      if (state_r == rtpe_pkg::ST_ENC_ADD) begin
        acc_r  <= acc_r | (AB'(code) << pend_r);
        pend_r <= pend_r + width;
      end
      if (w1_emit) begin
        acc_r   <= acc_r >> 32;
        pend_r  <= pend_r - 6'd32;
        words_r <= words_inc;
      end
      if (state_r == rtpe_pkg::ST_ENC_W2 && last_r &&
          (pend_r == 6'd0 || out_free)) begin
        acc_r   <= '0;
        pend_r  <= '0;
        words_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_tdata[7:0];
      idx_r  <= in_tdata[14:8];
      last_r <= in_tlast;
    end
    if (cnt_we && last_r) v_r <= 8'd0;
    if (state_r == rtpe_pkg::ST_B_LDV) begin
      cv_r   <= cnt_eff;
      u_r    <= 8'd0;
      rank_r <= 8'd0;
    end
    if (state_r == rtpe_pkg::ST_B_CMP) begin
      rank_r <= rank_r + {7'd0, beats};
      u_r    <= u_r + 8'd1;
    end
    if (rank_we) v_r <= v_r + 8'd1;
    if (w1_emit) begin
      out_kind_r <= rtpe_pkg::KIND_WORD;
      out_word_r <= acc_r[31:0];
      out_sym_r  <= 8'd0;
      out_end_r  <= last_r && (pend_r == 6'd32);
      out_len_r  <= (last_r && pend_r == 6'd32) ? {words_inc, 2'b00} : 13'd0;
    end
    if (w2_emit) begin
      out_kind_r <= rtpe_pkg::KIND_WORD;
      out_word_r <= acc_r[31:0];
      out_sym_r  <= 8'd0;
      out_end_r  <= 1'b1;
      out_len_r  <= {words_inc, 2'b00};
    end
    if (rd_emit) begin
      out_kind_r <= rtpe_pkg::KIND_SYMBOL;
      out_word_r <= 32'd0;
      out_sym_r  <= !idx_in_book ? 8'd0 : (book_ok_r ? book_q : {1'b0, idx_r});
      out_end_r  <= 1'b0;
      out_len_r  <= 13'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_len_r, out_sym_r, out_word_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_end_r;

  `RTPE_ASSERT_IMP(a_idle_pend, state_r == rtpe_pkg::ST_IDLE, pend_r < 6'd32,
                   "pending bits overflow")
  `RTPE_ASSERT_IMP(a_end_is_word, out_valid_r && out_end_r,
                   out_kind_r == rtpe_pkg::KIND_WORD, "segment end on symbol")
  `RTPE_ASSERT_IMP(a_sym_clean, out_valid_r && out_kind_r == rtpe_pkg::KIND_SYMBOL,
                   out_word_r == 32'd0 && out_len_r == 13'd0,
                   "symbol result carries word fields")
endmodule
`default_nettype wire

// ===== test/rtpe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpe_checker
// watches both stream channels of the ranked tier prefix encoder, keeps its
// own histogram, codebook and bit packer, and compares every result transfer
// ----------------------------------------------------------------------------
module rtpe_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [15:0] in_tdata,
  input  wire  [1:0]  in_tuser,
  input  wire         in_tlast,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [55:0] out_tdata,
  input  wire         out_tuser,
  input  wire         out_tlast,
  output int          fail_count,
  output int          results_due
);

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic [7:0]  symbol;
    logic        seg_end;
    logic [12:0] seg_len;
  } coded_result_t;

  // small ring of predicted results, oldest at due_rd
  coded_result_t due_mem[16];
  logic [3:0]    due_wr;
  logic [3:0]    due_rd;
  int            due_n;

  logic [rtpe_pkg::COUNT_BITS-1:0] hist[256];
  logic [7:0]            value_rank[256];
  logic [7:0]            book[rtpe_pkg::BOOK_ENTRIES];
  logic [63:0]           bit_acc;
  int                    bit_cnt;
  int                    word_cnt;
  int                    fails;

  function automatic coded_result_t word_result(logic [31:0] w);
    coded_result_t r;
    r = '0;
    r.kind = rtpe_pkg::KIND_WORD;
    r.word = w;
    return r;
  endfunction

  task automatic add_due(coded_result_t r);
    due_mem[due_wr] = r;
    due_wr = due_wr + 4'd1;
    due_n++;
  endtask

  task automatic rank_histogram();
    int rnk;
    for (int v = 0; v < 256; v++) begin
      rnk = 0;
      for (int u = 0; u < 256; u++) begin
        if (hist[u] > hist[v] || (hist[u] == hist[v] && u < v)) rnk++;
      end
      value_rank[v] = 8'(rnk);
      if (rnk < rtpe_pkg::BOOK_ENTRIES) book[rnk] = 8'(v);
    end
    for (int v = 0; v < 256; v++) hist[v] = '0;
  endtask

  task automatic encode_byte(logic [7:0] b, logic seg_last);
    int rnk;
    logic [63:0] code;
    int width;
    int n;
    logic [3:0] tail;
    rnk = value_rank[b];
    n = 0;
    if (rnk < rtpe_pkg::SMALL_TIER) begin
      code = 64'(rnk << 1);
      width = 3;
    end else if (rnk < rtpe_pkg::SMALL_TIER + rtpe_pkg::MEDIUM_TIER) begin
      code = 64'(1 | ((rnk - rtpe_pkg::SMALL_TIER) << 2));
      width = 6;
    end else if (rnk < rtpe_pkg::BOOK_ENTRIES) begin
      code = 64'(3 | ((rnk - rtpe_pkg::SMALL_TIER - rtpe_pkg::MEDIUM_TIER) << 3));
      width = 9;
    end else begin
      code = 64'(7 | (int'(b) << 3));
      width = 11;
    end
    bit_acc = bit_acc | (code << bit_cnt);
    bit_cnt += width;
    if (bit_cnt >= 32) begin
      add_due(word_result(bit_acc[31:0]));
      bit_acc = bit_acc >> 32;
      bit_cnt -= 32;
      if (word_cnt < 2047) word_cnt++;
      n++;
    end
    if (seg_last) begin
      if (bit_cnt > 0) begin
        add_due(word_result(bit_acc[31:0]));
        if (word_cnt < 2047) word_cnt++;
        n++;
      end
      if (n > 0) begin
        tail = due_wr - 4'd1;
        due_mem[tail].seg_end = 1'b1;
        due_mem[tail].seg_len = 13'(word_cnt * 4);
      end
      bit_acc = '0;
      bit_cnt = 0;
      word_cnt = 0;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    due_wr = '0;
    due_rd = '0;
    due_n = 0;
    for (int v = 0; v < 256; v++) begin
      hist[v] = '0;
      value_rank[v] = 8'(v);
    end
    for (int i = 0; i < rtpe_pkg::BOOK_ENTRIES; i++) book[i] = 8'(i);
    bit_acc = '0;
    bit_cnt = 0;
    word_cnt = 0;
  end

  always @(posedge clk) begin
    coded_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_n == 0) begin
          report_mismatch("unexpected result transfer", out_tdata[31:0], '0);
        end else begin
          want = due_mem[due_rd];
          due_rd = due_rd + 4'd1;
          due_n--;
          if (out_tuser !== want.kind)
            report_mismatch("result_kind", 32'(out_tuser), 32'(want.kind));
          if (out_tdata[31:0] !== want.word)
            report_mismatch("packed_word", out_tdata[31:0], want.word);
          if (out_tdata[39:32] !== want.symbol)
            report_mismatch("codebook_symbol", 32'(out_tdata[39:32]), 32'(want.symbol));
          if (out_tlast !== want.seg_end)
            report_mismatch("segment_end", 32'(out_tlast), 32'(want.seg_end));
          if (out_tdata[52:40] !== want.seg_len)
            report_mismatch("segment_length_bytes", 32'(out_tdata[52:40]),
                            32'(want.seg_len));
          if (out_tdata[55:53] !== 3'b000)
            report_mismatch("tdata padding", 32'(out_tdata[55:53]), '0);
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          rtpe_pkg::MODE_COUNT: begin
            if (hist[in_tdata[7:0]] != rtpe_pkg::COUNT_MAX) hist[in_tdata[7:0]]++;
            if (in_tlast) rank_histogram();
          end
          rtpe_pkg::MODE_ENCODE: encode_byte(in_tdata[7:0], in_tlast);
          rtpe_pkg::MODE_READ: begin
            want = '0;
            want.kind = rtpe_pkg::KIND_SYMBOL;
            if (in_tdata[14:8] < rtpe_pkg::BOOK_ENTRIES) want.symbol = book[in_tdata[14:8]];
            add_due(want);
          end
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    results_due <= due_n;
  end

endmodule

// ===== test/tb_ranked_tier_prefix_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ranked_tier_prefix_encoder
// drives histogram passes, encode segments and codebook reads with random
// gaps and back-pressure; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb_ranked_tier_prefix_encoder;

  // the limit must outlast a ranking pass, which runs without a transfer
  localparam int QUIET_LIMIT = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // data_byte[7:0], rank_index[14:8], zero
  logic [1:0]  in_tuser;   // mode[1:0]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // packed_word[31:0], codebook_symbol[39:32],
                           // segment_length_bytes[52:40], zero
  logic        out_tuser;  // result_kind
  logic        out_tlast;  // segment_end

  int fail_count;
  int results_due;
  int tx_idle_pct;
  int rx_idle_pct;
  int quiet_cycles;
  bit rx_hold_req;
  bit rx_hold_done;

  ranked_tier_prefix_encoder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  rtpe_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .results_due(results_due)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    rx_hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] mode, logic [7:0] b, logic seg_last,
                           logic [6:0] rank_idx);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, rank_idx, b};
    in_tuser <= mode;
    in_tlast <= seg_last;
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_random(int n);
    logic [1:0] mode;
    logic [7:0] b;
    int pick;
    pick = $urandom_range(99);
    b = ($urandom_range(1) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
    if (pick < 60) mode = rtpe_pkg::MODE_ENCODE;
    else if (pick < 80) mode = rtpe_pkg::MODE_COUNT;
    else if (pick < 95) mode = rtpe_pkg::MODE_READ;
    else mode = 2'd3;
    // only two more ranking passes fit in the run
    if (n == 400 || n == 1100)
      send_item(rtpe_pkg::MODE_COUNT, b, 1'b1, 7'($urandom));
    else
      send_item(mode, b, (mode == rtpe_pkg::MODE_COUNT) ? 1'b0 : ($urandom_range(24) == 0),
                7'($urandom));
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= rtpe_pkg::MODE_COUNT;
    in_tlast <= 1'b0;
    rx_hold_req = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before any pass: rank equals value, so high bytes escape
    send_item(rtpe_pkg::MODE_ENCODE, 8'd0, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_ENCODE, 8'd255, 1'b0, 7'd127);
    send_item(rtpe_pkg::MODE_ENCODE, 8'd83, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_ENCODE, 8'd19, 1'b1, 7'd0);
    send_item(rtpe_pkg::MODE_READ, 8'd0, 1'b1, 7'd83);
    send_item(rtpe_pkg::MODE_READ, 8'd0, 1'b0, 7'd84);
    send_item(2'd3, 8'd170, 1'b1, 7'd85);
    // histogram with a tie between 200 and 9, then pass end
    send_item(rtpe_pkg::MODE_COUNT, 8'd200, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_COUNT, 8'd9, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_COUNT, 8'd200, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_COUNT, 8'd9, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_COUNT, 8'd255, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_COUNT, 8'd77, 1'b1, 7'd0);
    send_item(rtpe_pkg::MODE_READ, 8'd0, 1'b0, 7'd0);
    send_item(rtpe_pkg::MODE_READ, 8'd0, 1'b0, 7'd1);
    send_item(rtpe_pkg::MODE_READ, 8'd0, 1'b1, 7'd2);
    send_item(rtpe_pkg::MODE_READ, 8'd0, 1'b0, 7'd127);
    for (int i = 0; i < 8; i++)
      send_item(rtpe_pkg::MODE_ENCODE, 8'(i * 37), i == 7, 7'd0);

    for (int n = 0; n < 1530; n++) begin
      if (n == 0) begin
        tx_idle_pct = 31;
        rx_idle_pct = 61;
      end else if (n == 510) begin
        tx_idle_pct = 61;
        rx_idle_pct = 31;
      end else if (n == 1020) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (n == 1200) rx_hold_req = 1'b1;
      if (n == 700) begin
        in_tvalid <= 1'b0;
        // let the count of the last transfer settle first
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
      end
      send_random(n);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
